// ===== src/segx_pkg.sv =====
// shared types and constants for the segment crossing pipeline
// used by every module under src; depends on nothing
package segx_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned ResW   = 32;

  typedef struct packed {
    logic signed [CoordW-1:0] first_start_x;
    logic signed [CoordW-1:0] first_start_y;
    logic signed [CoordW-1:0] first_end_x;
    logic signed [CoordW-1:0] first_end_y;
    logic signed [CoordW-1:0] second_start_x;
    logic signed [CoordW-1:0] second_start_y;
    logic signed [CoordW-1:0] second_end_x;
    logic signed [CoordW-1:0] second_end_y;
  } seg_in_t;

  typedef struct packed {
    logic                   hit;
    logic signed [ResW-1:0] cross_x;
    logic signed [ResW-1:0] cross_y;
  } seg_out_t;

endpackage

// ===== src/segx_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// magnitude in, magnitude out; sign handled by the caller; uses segx_pkg
module segx_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 34,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [NUM_W-1:0] quot,
  output logic [TAG_W-1:0] out_tag
);
  import segx_pkg::*;

  // per stage output: remainder, shifting numerator/quotient word, divisor, tag
  logic             vld [NUM_W];
  logic [DEN_W:0]   rem [NUM_W];
  logic [NUM_W-1:0] nq  [NUM_W];
  logic [DEN_W-1:0] dv  [NUM_W];
  logic [TAG_W-1:0] tg  [NUM_W];

  // one bit per stage: shift in the next numerator bit, subtract if it fits
  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic             v_in;
    logic [DEN_W:0]   r_in;
    logic [NUM_W-1:0] q_in;
    logic [DEN_W-1:0] d_in;
    logic [TAG_W-1:0] t_in;
    logic [DEN_W+1:0] sh;
    logic [DEN_W+1:0] df;

    // stage input from the ports or from the previous stage
    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = '0;
      assign q_in = num;
      assign d_in = den;
      assign t_in = in_tag;
    end else begin : g_next
      assign v_in = vld[i-1];
      assign r_in = rem[i-1];
      assign q_in = nq[i-1];
      assign d_in = dv[i-1];
      assign t_in = tg[i-1];
    end

    assign sh = {r_in, q_in[NUM_W-1]};
    assign df = sh - {2'b00, d_in};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= v_in;
      end
      if (!df[DEN_W+1]) begin
        rem[i] <= df[DEN_W:0];
      end else begin
        rem[i] <= sh[DEN_W:0];
      end
      nq[i] <= {q_in[NUM_W-2:0], ~df[DEN_W+1]};
      dv[i] <= d_in;
      tg[i] <= t_in;
    end
  end

  assign out_valid = vld[NUM_W-1];
  assign quot      = nq[NUM_W-1];
  assign out_tag   = tg[NUM_W-1];
endmodule

// ===== src/segx_front.sv =====
// front pipeline: differences, products, determinant and crossing numerators
// uses segx_pkg; feeds the dividers in segment_intersection
module segx_front #(
  parameter int CW = 16,
  parameter int NW = 68
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] x1, y1, x2, y2, x3, y3, x4, y4,
  output logic                 out_valid,
  output logic signed [2*CW+2:0] det,
  output logic signed [NW-1:0] nx,
  output logic signed [NW-1:0] ny
);
  import segx_pkg::*;

  localparam int DW = CW + 1;
  localparam int PW = 2 * CW + 2;

  // stage 1: differences and endpoint cross products
  logic              v1;
  logic signed [DW-1:0] dx1, dy1, dx2, dy2;
  logic signed [PW-1:0] p_a, p_b, p_c, p_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    dx1 <= DW'(x1) - DW'(x2);
    dy1 <= DW'(y1) - DW'(y2);
    dx2 <= DW'(x3) - DW'(x4);
    dy2 <= DW'(y3) - DW'(y4);
    p_a <= PW'(x1) * PW'(y2);
    p_b <= PW'(y1) * PW'(x2);
    p_c <= PW'(x3) * PW'(y4);
    p_d <= PW'(y3) * PW'(x4);
  end

  // stage 2: pre, post and direction products
  localparam int QW = PW + 1;
  logic              v2;
  logic signed [DW-1:0] dx1_2, dy1_2, dx2_2, dy2_2;
  logic signed [QW-1:0] pre, post;
  logic signed [QW-1:0] m_a, m_b;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    dx1_2 <= dx1;
    dy1_2 <= dy1;
    dx2_2 <= dx2;
    dy2_2 <= dy2;
    pre   <= QW'(p_a) - QW'(p_b);
    post  <= QW'(p_c) - QW'(p_d);
    m_a   <= QW'(dx1) * QW'(dy2);
    m_b   <= QW'(dy1) * QW'(dx2);
  end

  // stage 3: four numerator products and the determinant
  logic              v3;
  logic signed [NW-1:0] t_a, t_b, t_c, t_d;
  logic signed [QW-1:0] det3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    t_a  <= NW'(pre) * NW'(dx2_2);
    t_b  <= NW'(dx1_2) * NW'(post);
    t_c  <= NW'(pre) * NW'(dy2_2);
    t_d  <= NW'(dy1_2) * NW'(post);
    det3 <= m_a - m_b;
  end

  // stage 4: numerators
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v3;
    end
    nx  <= t_a - t_b;
    ny  <= t_c - t_d;
    det <= det3;
  end
endmodule

// ===== src/segment_intersection.sv =====
// top level of the segment crossing pipeline
// uses segx_pkg, segx_front and segx_div
//
// Fully pipelined: a new segment pair is taken every cycle (busy stays low)
// and its result word appears with done high after 4 front stages,
// 3*CoordW+FRAC_BITS+5 divider stages (one quotient bit each), and 2 stages
// for sign fix and bound check. The coordinate width is the package
// constant CoordW. The receiver cannot stall; every result is on the result
// ports for exactly one cycle.
module segment_intersection #(
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  segx_pkg::seg_in_t  in_word,
  output logic               done,
  output segx_pkg::seg_out_t out_word
);
  import segx_pkg::*;

  localparam int CW  = CoordW;
  localparam int DTW = 2 * CW + 3;
  localparam int NW  = 3 * CW + 5;
  localparam int SW  = NW + FRAC_BITS;
  localparam int TW  = 8 * CW;

  assign busy = 1'b0;

  logic signed [CW-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
  assign x1 = in_word.first_start_x[CW-1:0];
  assign y1 = in_word.first_start_y[CW-1:0];
  assign x2 = in_word.first_end_x[CW-1:0];
  assign y2 = in_word.first_end_y[CW-1:0];
  assign x3 = in_word.second_start_x[CW-1:0];
  assign y3 = in_word.second_start_y[CW-1:0];
  assign x4 = in_word.second_end_x[CW-1:0];
  assign y4 = in_word.second_end_y[CW-1:0];

  // coordinates travel next to the front pipeline
  logic [8*CW-1:0] crd_in;
  logic [8*CW-1:0] crd [4];
  assign crd_in = {x1, y1, x2, y2, x3, y3, x4, y4};
  always_ff @(posedge clk) begin
    crd[0] <= crd_in;
    for (int i = 1; i < 4; i++) begin
      crd[i] <= crd[i-1];
    end
  end

  logic                  f_valid;
  logic signed [DTW-1:0] det;
  logic signed [NW-1:0]  nx, ny;

  segx_front #(.CW(CW), .NW(NW)) u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy),
    .x1(x1), .y1(y1), .x2(x2), .y2(y2), .x3(x3), .y3(y3), .x4(x4), .y4(y4),
    .out_valid(f_valid), .det(det), .nx(nx), .ny(ny)
  );

  // magnitudes and signs into the dividers
  logic signed [SW-1:0] sx, sy;
  logic [SW-1:0]        ax, ay;
  logic [DTW-1:0]       ad;
  logic                 negx, negy, dzero;
  always_comb begin
    sx    = SW'(nx) <<< FRAC_BITS;
    sy    = SW'(ny) <<< FRAC_BITS;
    ax    = sx[SW-1] ? SW'(-sx) : SW'(sx);
    ay    = sy[SW-1] ? SW'(-sy) : SW'(sy);
    ad    = det[DTW-1] ? DTW'(-det) : DTW'(det);
    negx  = sx[SW-1] ^ det[DTW-1];
    negy  = sy[SW-1] ^ det[DTW-1];
    dzero = (det == '0);
  end

  logic            qx_valid, qy_valid;
  logic [SW-1:0]   qx_mag, qy_mag;
  logic [TW+1:0]   tag_x;
  logic            tag_y;

  segx_div #(.NUM_W(SW), .DEN_W(DTW), .TAG_W(TW+2)) u_div_x (
    .clk(clk), .rst(rst), .in_valid(f_valid), .num(ax),
    .den(dzero ? DTW'(1) : ad), .in_tag({negx, dzero, crd[3]}),
    .out_valid(qx_valid), .quot(qx_mag), .out_tag(tag_x)
  );

  segx_div #(.NUM_W(SW), .DEN_W(DTW), .TAG_W(1)) u_div_y (
    .clk(clk), .rst(rst), .in_valid(f_valid), .num(ay),
    .den(dzero ? DTW'(1) : ad), .in_tag(negy),
    .out_valid(qy_valid), .quot(qy_mag), .out_tag(tag_y)
  );

  // sign fix stage
  logic                 v_s;
  logic signed [SW-1:0] qx, qy;
  logic                 dz_s;
  logic [8*CW-1:0]      crd_s;
  always_ff @(posedge clk) begin
    if (rst) begin
      v_s <= 1'b0;
    end else begin
      v_s <= qx_valid && qy_valid;
    end
    qx    <= tag_x[TW+1] ? SW'(-qx_mag) : SW'(qx_mag);
    qy    <= tag_y ? SW'(-qy_mag) : SW'(qy_mag);
    dz_s  <= tag_x[TW];
    crd_s <= tag_x[TW-1:0];
  end

  // bound check against scaled endpoints
  function automatic logic inside_rng(logic signed [SW-1:0] v,
                                      logic signed [CW-1:0] a,
                                      logic signed [CW-1:0] b);
    logic signed [SW-1:0] lo, hi;
    begin
      lo = (a < b) ? SW'(a) : SW'(b);
      hi = (a < b) ? SW'(b) : SW'(a);
      lo = lo <<< FRAC_BITS;
      hi = hi <<< FRAC_BITS;
      return (v >= lo) && (v <= hi);
    end
  endfunction

  logic signed [CW-1:0] cx1, cy1, cx2, cy2, cx3, cy3, cx4, cy4;
  assign {cx1, cy1, cx2, cy2, cx3, cy3, cx4, cy4} = crd_s;

  logic hit_c;
  assign hit_c = !dz_s && inside_rng(qx, cx1, cx2) && inside_rng(qx, cx3, cx4)
              && inside_rng(qy, cy1, cy2) && inside_rng(qy, cy3, cy4);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_s;
    end
    out_word.hit     <= hit_c;
    out_word.cross_x <= hit_c ? ResW'(qx) : '0;
    out_word.cross_y <= hit_c ? ResW'(qy) : '0;
  end
endmodule

// ===== test/segment_intersection_test.sv =====
// self-checking test of the segment crossing pipeline
// depends on segx_pkg and segment_intersection under src
module segment_intersection_test;
  timeunit 1ns;
  timeprecision 1ps;
  import segx_pkg::*;

  localparam int FracBits = 16;
  localparam int Latency  = 4 + 3 * 16 + FracBits + 5 + 2;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  logic     done;
  seg_in_t  in_word = '0;
  seg_out_t out_word;

  seg_out_t crossing_q[$];
  int       error_count = 0;
  bit       quiet_gaps = 1'b0;

  segment_intersection dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_word(in_word), .done(done), .out_word(out_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit in_range(logic signed [127:0] v, longint a, longint b,
                                  longint one);
    longint lo, hi;
    lo = (a < b ? a : b) * one;
    hi = (a < b ? b : a) * one;
    return v >= 128'(signed'(lo)) && v <= 128'(signed'(hi));
  endfunction

  // predicted crossing of one segment pair
  function automatic seg_out_t predict_crossing(seg_in_t w);
    longint x1, y1, x2, y2, x3, y3, x4, y4, det, pre, post, one;
    logic signed [127:0] nx, ny, qx, qy;
    seg_out_t r;
    x1 = w.first_start_x;  y1 = w.first_start_y;
    x2 = w.first_end_x;    y2 = w.first_end_y;
    x3 = w.second_start_x; y3 = w.second_start_y;
    x4 = w.second_end_x;   y4 = w.second_end_y;
    r = '0;
    det = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
    if (det == 0) return r;
    pre  = x1 * y2 - y1 * x2;
    post = x3 * y4 - y3 * x4;
    nx = 128'(signed'(pre)) * (x3 - x4) - 128'(signed'(x1 - x2)) * post;
    ny = 128'(signed'(pre)) * (y3 - y4) - 128'(signed'(y1 - y2)) * post;
    // signed division truncates toward zero
    qx = (nx <<< FracBits) / 128'(signed'(det));
    qy = (ny <<< FracBits) / 128'(signed'(det));
    one = longint'(1) <<< FracBits;
    if (in_range(qx, x1, x2, one) && in_range(qx, x3, x4, one) &&
        in_range(qy, y1, y2, one) && in_range(qy, y3, y4, one)) begin
      r.hit = 1'b1;
      r.cross_x = qx[31:0];
      r.cross_y = qy[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, seg_out_t got, seg_out_t want);
    error_count++;
    $display("error %s: got %0d %0d %0d want %0d %0d %0d", what, got.hit,
             got.cross_x, got.cross_y, want.hit, want.cross_x, want.cross_y);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (crossing_q.size() == 0)
        report_mismatch("unexpected word", out_word, '0);
      else begin
        seg_out_t want;
        want = crossing_q.pop_front();
        if (out_word.hit !== want.hit || out_word.cross_x !== want.cross_x ||
            out_word.cross_y !== want.cross_y)
          report_mismatch("word", out_word, want);
      end
    end
  end

  // send one word, with random idle gaps
  task automatic send_word(seg_in_t w);
    while (!quiet_gaps && $urandom_range(99) < 24) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    crossing_q.push_back(predict_crossing(w));
    @(negedge clk);
  endtask

  function automatic logic [15:0] edge_coord();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic seg_in_t pack_pair(int a, int b, int c, int d, int e, int f,
                                        int g, int h);
    return {16'(a), 16'(b), 16'(c), 16'(d), 16'(e), 16'(f), 16'(g), 16'(h)};
  endfunction

  task automatic test_directed();
    send_word(pack_pair(0, 0, 10, 10, 0, 10, 10, 0));          // plain cross
    send_word(pack_pair(0, 0, 10, 0, 0, 5, 10, 5));            // parallel
    send_word(pack_pair(0, 0, 10, 10, 2, 2, 8, 8));            // collinear
    send_word(pack_pair(3, 3, 3, 3, 0, 5, 10, 5));             // zero length
    send_word(pack_pair(0, 0, 10, 0, 5, -5, 5, 0));            // touch at endpoint
    send_word(pack_pair(0, 0, 4, 4, 10, 0, 6, 4));             // lines cross outside
    send_word(pack_pair(0, 0, 3, 1, 0, 1, 3, 0));              // fractional point
    send_word(pack_pair(-3, -1, 0, 0, -3, 0, 0, -1));          // negative fraction
    send_word(pack_pair(-32768, -32768, 32767, 32767,
                        -32768, 32767, 32767, -32768));        // full extremes
    send_word(pack_pair(32767, -32768, -32768, 32767,
                        -32768, -32768, 32767, 32767));
    send_word(pack_pair(-32768, 0, 32767, 1, -32768, 1, 32767, 0));
    send_word('1);
    send_word('0);
    for (int i = 0; i < 8; i++)
      send_word({edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                 edge_coord(), edge_coord(), edge_coord(), edge_coord()});
  endtask

  // mostly crossing pairs around a random center, some noise
  task automatic test_random(int count);
    seg_in_t w;
    int cx, cy, s;
    for (int i = 0; i < count; i++) begin
      quiet_gaps = (i >= count / 3 && i < count / 2);
      cx = $urandom_range(65535) - 32768;
      cy = $urandom_range(65535) - 32768;
      s  = 1 << $urandom_range(14);
      case ($urandom_range(9))
        0, 1: w = seg_in_t'({$urandom, $urandom, $urandom, $urandom});
        2: w = {edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                edge_coord(), edge_coord(), edge_coord(), edge_coord()};
        3: begin
          w = seg_in_t'({$urandom, $urandom, $urandom, $urandom});
          w.second_start_x = w.first_start_x; w.second_start_y = w.first_start_y;
        end
        default: begin
          w = pack_pair(cx - $urandom_range(s), cy - $urandom_range(s),
                        cx + $urandom_range(s), cy + $urandom_range(s),
                        cx - $urandom_range(s), cy + $urandom_range(s),
                        cx + $urandom_range(s), cy - $urandom_range(s));
        end
      endcase
      send_word(w);
    end
    quiet_gaps = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(1700);
    start <= 1'b0;
    while (crossing_q.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (error_count == 0)
      $display("segment_intersection: match");
    else
      $display("segment_intersection: mismatch");
    $finish;
  end

  initial begin
    #200000;
    $display("segment_intersection: mismatch");
    $finish;
  end
endmodule
